### sv/smoothed_point_charge_potential_grid_unit_macros.svh
// assertion helpers shared by the grid unit
`ifndef SMOOTHED_POINT_CHARGE_POTENTIAL_GRID_UNIT_MACROS_SVH
`define SMOOTHED_POINT_CHARGE_POTENTIAL_GRID_UNIT_MACROS_SVH

// same-cycle implication
`define SPCPG_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("spcpg check failed");

// next-cycle implication
`define SPCPG_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("spcpg check failed");

`endif

### sv/spcpg_pkg.sv
package spcpg_pkg;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] CFG_SPACING_X    = 2'd0;
    localparam logic [1:0] CFG_SPACING_Y    = 2'd1;
    localparam logic [1:0] CFG_SPACING_Z    = 2'd2;
    localparam logic [1:0] CFG_CHARGE_COUNT = 2'd3;

    localparam logic [15:0] SPACING_RESET = 16'd13107;

    // r = 0.7558904 * 0.25 in Q.16
    localparam logic [32:0] R_Q16 = 33'd12385;
    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [63:0] INV_DIVIDEND = 64'h0000_4000_0000_0000;
    localparam logic [60:0] MAG_ROUND = 61'h80_0000;

    localparam logic signed [63:0] POT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] POT_MIN = -64'sh0000_8000_0000_0000;

    localparam logic [5:0] SQ_STEPS  = 6'd33;
    localparam logic [5:0] DIV_STEPS = 6'd33;

    localparam int unsigned MEM_W = 120;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [32:0] divisor;
    } t_div_req;

    typedef enum logic [4:0] {
        S_IDLE, S_READ, S_DX, S_MX, S_MY, S_MZ, S_SQS, S_SQW, S_MN,
        S_DTS, S_DTW, S_DIS, S_DIW, S_T2, S_T3, S_T4, S_NUM,
        S_DPS, S_DPW, S_F, S_MAG, S_ACC, S_FIN
    } t_state;

endpackage

### sv/spcpg_ram.sv
module spcpg_ram #(
    parameter int unsigned W  = 8,
    parameter int unsigned D  = 16,
    parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/spcpg_isqrt.sv
module spcpg_isqrt import spcpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_radicand,
    output logic        o_done,
    output logic [32:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [65:0] r_rad;
    logic [34:0] r_rem;
    logic [32:0] r_root;

    logic [36:0] w_trem;
    logic [36:0] w_trial;
    logic [36:0] w_diff;
    logic        w_ge;

    // one result bit per step, two radicand bits shifted in
    assign w_trem  = {r_rem, r_rad[65:64]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_diff  = w_trem - w_trial;
    assign w_ge    = (w_trem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SQ_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= 35'd0;
            r_root <= 33'd0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[63:0], 2'b00};
            r_rem  <= w_ge ? w_diff[34:0] : w_trem[34:0];
            r_root <= {r_root[31:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

### sv/spcpg_div.sv
module spcpg_div import spcpg_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [32:0] o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [32:0] r_rem;
    logic [32:0] r_low;
    logic [32:0] r_dvs;
    logic [32:0] r_quo;

    logic [33:0] w_trem;
    logic [33:0] w_diff;
    logic        w_ge;

    // restoring division; the upper dividend bits start below the divisor
    assign w_trem = {r_rem, r_low[32]};
    assign w_diff = w_trem - {1'b0, r_dvs};
    assign w_ge   = (w_trem >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= {2'b00, i_req.dividend[63:33]};
            r_low <= i_req.dividend[32:0];
            r_dvs <= i_req.divisor;
            r_quo <= 33'd0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[32:0] : w_trem[32:0];
            r_low <= {r_low[31:0], 1'b0};
            r_quo <= {r_quo[31:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

### sv/smoothed_point_charge_potential_grid_unit.sv
// load item: written into the charge memory at the transfer, no result
// evaluate item: result for N summed charges goes to the output register, and the next
// item is taken once the output register is free; each charge uses
// the square-root unit and three runs of the shared divider (33 steps each)
// reset (synchronous, active low) restores spacings and count and clears control;
// the charge memory keeps its contents and is not cleared
`include "smoothed_point_charge_potential_grid_unit_macros.svh"

module smoothed_point_charge_potential_grid_unit import spcpg_pkg::*; #(
    parameter int unsigned MAX_CHARGES = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // slot, charge_x, charge_y, charge_z, charge_value, grid_i, grid_j, grid_k
    input  logic [167:0] s_axis_tdata,
    // command
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // potential, singular_hit, saturated
    output logic [55:0]  m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [15:0]  i_cfg_data
);

    localparam int unsigned AW   = (MAX_CHARGES > 1) ? $clog2(MAX_CHARGES) : 1;
    localparam int unsigned CMPW = ((AW > 7) ? AW : 7) + 1;

    t_state r_state, n_state;

    logic [15:0] r_spx, r_spy, r_spz;
    logic [6:0]  r_ccount;
    logic [27:0] r_px, r_py, r_pz;
    logic [6:0]  r_cnt;
    logic [AW-1:0] r_idx;
    logic [31:0] r_ax, r_ay, r_az;
    logic [65:0] r_sumsq;
    logic [32:0] r_d, r_m, r_n;
    logic [30:0] r_t, r_t2, r_t3, r_t4, r_p;
    logic [32:0] r_num, r_den, r_inv;
    logic [35:0] r_f;
    logic [23:0] r_qa;
    logic        r_qpos, r_qneg;
    logic [36:0] r_mag;
    logic signed [63:0] r_acc;
    logic        r_sing;
    logic        r_out_valid;
    logic [49:0] r_out_data;

    logic        w_in_xfer;
    logic [5:0]  w_slot;
    logic        w_we;
    logic        w_re;
    logic [MEM_W-1:0] w_wdata, w_rdata;
    logic [31:0] w_rd_x, w_rd_y, w_rd_z;
    logic [23:0] w_rd_q, w_q_neg;
    logic [6:0]  w_cnt;
    logic        w_last;
    logic        w_out_free;
    logic [31:0] w_sq_op;
    logic [63:0] w_sq;
    logic [30:0] w_tm_op;
    logic [61:0] w_tprod;
    logic [31:0] w_na, w_nb;
    logic [63:0] w_nprod;
    logic [63:0] w_fprod;
    logic [60:0] w_mprod;
    logic        sq_start, sq_done;
    logic [32:0] sq_root;
    t_div_req    div_req;
    logic        div_done;
    logic [32:0] div_quot;

    function automatic logic [31:0] f_abs(input logic [33:0] v);
        logic [33:0] neg;
        neg = 34'd0 - v;
        f_abs = v[33] ? neg[31:0] : v[31:0];
    endfunction

    assign w_in_xfer = s_axis_tvalid && s_axis_tready;
    assign w_slot    = s_axis_tdata[5:0];
    assign w_we      = w_in_xfer && (s_axis_tuser == CMD_LOAD) && (32'(w_slot) < MAX_CHARGES);
    assign w_wdata   = {s_axis_tdata[125:102], s_axis_tdata[101:70],
                        s_axis_tdata[69:38], s_axis_tdata[37:6]};
    assign w_re      = (r_state == S_READ);

    spcpg_ram #(.W(MEM_W), .D(MAX_CHARGES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(w_slot)),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_idx),
        .o_rdata (w_rdata)
    );

    assign w_rd_x  = w_rdata[31:0];
    assign w_rd_y  = w_rdata[63:32];
    assign w_rd_z  = w_rdata[95:64];
    assign w_rd_q  = w_rdata[119:96];
    assign w_q_neg = 24'd0 - w_rd_q;

    assign w_cnt  = (32'(r_ccount) > MAX_CHARGES) ? 7'(MAX_CHARGES) : r_ccount;
    assign w_last = ({{(CMPW-AW){1'b0}}, r_idx} + CMPW'(1)) == {{(CMPW-7){1'b0}}, r_cnt};
    assign w_out_free = !r_out_valid || m_axis_tready;

    // shared squarer for the three distance components
    always_comb begin
        case (r_state)
            S_MY:    w_sq_op = r_ay;
            S_MZ:    w_sq_op = r_az;
            default: w_sq_op = r_ax;
        endcase
    end
    assign w_sq = 64'(w_sq_op) * 64'(w_sq_op);

    // powers of t, one multiply per cycle
    always_comb begin
        case (r_state)
            S_T3:    w_tm_op = r_t2;
            S_T4:    w_tm_op = r_t3;
            default: w_tm_op = r_t;
        endcase
    end
    assign w_tprod = 62'(w_tm_op) * 62'(r_t);

    assign w_na    = ONE_Q30 + {1'b0, r_t};
    assign w_nb    = ONE_Q30 + {1'b0, r_t2};
    assign w_nprod = 64'(w_na) * 64'(w_nb);
    assign w_fprod = 64'(r_inv) * 64'(r_p);
    assign w_mprod = 61'(r_qa) * 61'(r_f) + MAG_ROUND;

    assign sq_start = (r_state == S_SQS);

    spcpg_isqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (r_sumsq),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = {1'b0, r_n, 30'd0};
        div_req.divisor  = r_m;
        case (r_state)
            S_DTS: begin
                div_req.start = 1'b1;
            end
            S_DIS: begin
                div_req.start    = 1'b1;
                div_req.dividend = INV_DIVIDEND;
            end
            S_DPS: begin
                div_req.start    = 1'b1;
                div_req.dividend = {1'b0, r_num, 30'd0};
                div_req.divisor  = r_den;
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    spcpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && s_axis_tuser == CMD_EVAL) begin
                    n_state = (w_cnt == 7'd0) ? S_FIN : S_READ;
                end
            end
            S_READ: n_state = S_DX;
            S_DX:   n_state = S_MX;
            S_MX:   n_state = S_MY;
            S_MY:   n_state = S_MZ;
            S_MZ:   n_state = S_SQS;
            S_SQS:  n_state = S_SQW;
            S_SQW:  n_state = sq_done ? S_MN : S_SQW;
            S_MN:   n_state = S_DTS;
            S_DTS:  n_state = S_DTW;
            S_DTW:  n_state = div_done ? S_DIS : S_DTW;
            S_DIS:  n_state = S_DIW;
            S_DIW:  n_state = div_done ? S_T2 : S_DIW;
            S_T2:   n_state = S_T3;
            S_T3:   n_state = S_T4;
            S_T4:   n_state = S_NUM;
            S_NUM:  n_state = S_DPS;
            S_DPS:  n_state = S_DPW;
            S_DPW:  n_state = div_done ? S_F : S_DPW;
            S_F:    n_state = S_MAG;
            S_MAG:  n_state = S_ACC;
            S_ACC:  n_state = w_last ? S_FIN : S_READ;
            S_FIN:  n_state = w_out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spx       <= SPACING_RESET;
            r_spy       <= SPACING_RESET;
            r_spz       <= SPACING_RESET;
            r_ccount    <= 7'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPACING_X:    r_spx    <= i_cfg_data;
                    CFG_SPACING_Y:    r_spy    <= i_cfg_data;
                    CFG_SPACING_Z:    r_spz    <= i_cfg_data;
                    CFG_CHARGE_COUNT: r_ccount <= i_cfg_data[6:0];
                    default:          r_ccount <= r_ccount;
                endcase
            end
            if (r_state == S_FIN && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_px   <= 28'(s_axis_tdata[137:126]) * 28'(r_spx);
                    r_py   <= 28'(s_axis_tdata[149:138]) * 28'(r_spy);
                    r_pz   <= 28'(s_axis_tdata[161:150]) * 28'(r_spz);
                    r_cnt  <= w_cnt;
                    r_idx  <= '0;
                    r_acc  <= 64'sd0;
                    r_sing <= 1'b0;
                end
            end
            S_DX: begin
                r_ax   <= f_abs({6'd0, r_px} - {{2{w_rd_x[31]}}, w_rd_x});
                r_ay   <= f_abs({6'd0, r_py} - {{2{w_rd_y[31]}}, w_rd_y});
                r_az   <= f_abs({6'd0, r_pz} - {{2{w_rd_z[31]}}, w_rd_z});
                r_qa   <= w_rd_q[23] ? w_q_neg : w_rd_q;
                r_qpos <= !w_rd_q[23] && (w_rd_q != 24'd0);
                r_qneg <= w_rd_q[23];
            end
            S_MX: r_sumsq <= {2'b00, w_sq};
            S_MY: r_sumsq <= r_sumsq + {2'b00, w_sq};
            S_MZ: r_sumsq <= r_sumsq + {2'b00, w_sq};
            S_SQW: begin
                if (sq_done) begin
                    r_d <= sq_root;
                end
            end
            S_MN: begin
                r_m <= (r_d > R_Q16) ? r_d : R_Q16;
                r_n <= (r_d > R_Q16) ? R_Q16 : r_d;
                if (r_d == R_Q16) begin
                    r_sing <= 1'b1;
                end
            end
            S_DTW: begin
                if (div_done) begin
                    r_t <= div_quot[30:0];
                end
            end
            S_DIW: begin
                if (div_done) begin
                    r_inv <= div_quot;
                end
            end
            S_T2: r_t2 <= w_tprod[60:30];
            S_T3: r_t3 <= w_tprod[60:30];
            S_T4: r_t4 <= w_tprod[60:30];
            S_NUM: begin
                r_num <= w_nprod[62:30];
                r_den <= {2'b00, ONE_Q30[30:0]} + {2'b00, r_t} + {2'b00, r_t2}
                         + {2'b00, r_t3} + {2'b00, r_t4};
            end
            S_DPW: begin
                if (div_done) begin
                    r_p <= div_quot[30:0];
                end
            end
            S_F:   r_f   <= w_fprod[63:28];
            S_MAG: r_mag <= w_mprod[60:24];
            S_ACC: begin
                if (r_qpos) begin
                    r_acc <= r_acc - $signed({27'd0, r_mag});
                end else if (r_qneg) begin
                    r_acc <= r_acc + $signed({27'd0, r_mag});
                end
                r_idx <= r_idx + AW'(1);
            end
            S_FIN: begin
                if (w_out_free) begin
                    if (r_acc > POT_MAX) begin
                        r_out_data <= {1'b1, r_sing, POT_MAX[47:0]};
                    end else if (r_acc < POT_MIN) begin
                        r_out_data <= {1'b1, r_sing, POT_MIN[47:0]};
                    end else begin
                        r_out_data <= {1'b0, r_sing, r_acc[47:0]};
                    end
                end
            end
            default: r_idx <= r_idx;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_data};

    `SPCPG_ASSERT_NXT(a_fin_holds, i_clk, i_rst_n,
        r_state == S_FIN && r_out_valid && !m_axis_tready, r_state == S_FIN)
    `SPCPG_ASSERT_IMP(a_sqrt_owner, i_clk, i_rst_n, sq_done, r_state == S_SQW)
    `SPCPG_ASSERT_IMP(a_div_owner, i_clk, i_rst_n, div_done,
        r_state == S_DTW || r_state == S_DIW || r_state == S_DPW)

endmodule

### tb/sv/smoothed_point_charge_potential_grid_unit_test.sv
`timescale 1ns / 1ps

module smoothed_point_charge_potential_grid_unit_test import spcpg_pkg::*; ();

    localparam int unsigned TABLE_DEPTH = 64;
    localparam int unsigned R_FIX = 12385;

    typedef struct {
        logic [47:0] potential;
        logic        singular_hit;
        logic        saturated;
    } t_pot_result;

    class potential_scoreboard;
        logic [15:0] spc_x, spc_y, spc_z;
        logic [6:0]  n_charges;
        logic [31:0] pos_x [TABLE_DEPTH];
        logic [31:0] pos_y [TABLE_DEPTH];
        logic [31:0] pos_z [TABLE_DEPTH];
        logic [23:0] amount [TABLE_DEPTH];
        t_pot_result expected_potentials [$];
        int errors;
        int n_loads;
        int n_evals;
        int n_singular;

        function new();
            spc_x = SPACING_RESET;
            spc_y = SPACING_RESET;
            spc_z = SPACING_RESET;
            n_charges = 0;
            errors = 0;
            n_loads = 0;
            n_evals = 0;
            n_singular = 0;
            for (int s = 0; s < TABLE_DEPTH; s++) begin
                pos_x[s] = 0;
                pos_y[s] = 0;
                pos_z[s] = 0;
                amount[s] = 0;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_SPACING_X: spc_x = val;
                CFG_SPACING_Y: spc_y = val;
                CFG_SPACING_Z: spc_z = val;
                CFG_CHARGE_COUNT: n_charges = val[6:0];
                default: ;
            endcase
        endfunction

        function automatic longint unsigned int_sqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function automatic longint unsigned diff_sq(longint unsigned p, logic [31:0] c);
            longint signed dd;
            longint unsigned a;
            dd = longint'(p) - longint'($signed(c));
            a = dd < 0 ? longint'(-dd) : longint'(dd);
            return a * a;
        endfunction

        function automatic longint unsigned distance(longint unsigned a, longint unsigned b,
                                                      longint unsigned c);
            longint unsigned low, q, rem, y, e;
            low = (a & 3) + (b & 3) + (c & 3);
            q = (a >> 2) + (b >> 2) + (c >> 2) + (low >> 2);
            rem = low & 3;
            y = int_sqrt(q);
            e = q - y * y;
            return (4 * y + 1 <= 4 * e + rem) ? 2 * y + 1 : 2 * y;
        endfunction

        // smoothed kernel in Q.32
        function automatic longint unsigned kernel(longint unsigned d);
            longint unsigned m, n, ms, ns, t, t2, t3, t4, num, den, p, inv, one;
            one = 64'd1 << 30;
            m = d > R_FIX ? d : R_FIX;
            n = d > R_FIX ? R_FIX : d;
            ms = m;
            ns = n;
            while ((ms >> 33) != 0) begin
                ms = ms >> 1;
                ns = ns >> 1;
            end
            t = (ns << 30) / ms;
            t2 = (t * t) >> 30;
            t3 = (t2 * t) >> 30;
            t4 = (t3 * t) >> 30;
            num = ((one + t) * (one + t2)) >> 30;
            den = one + t + t2 + t3 + t4;
            p = (num << 30) / den;
            inv = (64'd1 << 46) / m;
            return (inv * p) >> 28;
        endfunction

        function void note_input(logic cmd, logic [5:0] slot, logic [31:0] cx,
                                 logic [31:0] cy, logic [31:0] cz, logic [23:0] q,
                                 logic [11:0] gi, logic [11:0] gj, logic [11:0] gk);
            longint unsigned px, py, pz, d, qa, mag;
            longint signed acc, qs;
            int cnt;
            t_pot_result r;
            if (cmd == CMD_LOAD) begin
                n_loads++;
                pos_x[slot] = cx;
                pos_y[slot] = cy;
                pos_z[slot] = cz;
                amount[slot] = q;
                return;
            end
            n_evals++;
            px = longint'(gi) * longint'(spc_x);
            py = longint'(gj) * longint'(spc_y);
            pz = longint'(gk) * longint'(spc_z);
            cnt = n_charges < TABLE_DEPTH ? n_charges : TABLE_DEPTH;
            acc = 0;
            r.singular_hit = 0;
            r.saturated = 0;
            for (int s = 0; s < cnt; s++) begin
                d = distance(diff_sq(px, pos_x[s]), diff_sq(py, pos_y[s]),
                             diff_sq(pz, pos_z[s]));
                qs = longint'($signed(amount[s]));
                qa = qs < 0 ? longint'(-qs) : longint'(qs);
                mag = (qa * kernel(d) + (64'd1 << 23)) >> 24;
                if (d == R_FIX) r.singular_hit = 1;
                if (qs > 0) acc = acc - longint'(mag);
                else if (qs < 0) acc = acc + longint'(mag);
            end
            if (acc > POT_MAX) begin
                acc = POT_MAX;
                r.saturated = 1;
            end
            if (acc < POT_MIN) begin
                acc = POT_MIN;
                r.saturated = 1;
            end
            r.potential = acc[47:0];
            if (r.singular_hit) n_singular++;
            expected_potentials.push_back(r);
        endfunction

        task check(logic [55:0] data);
            t_pot_result e;
            if (expected_potentials.size() == 0) begin
                report($sformatf("unexpected result %h", data));
                return;
            end
            e = expected_potentials.pop_front();
            if (data[47:0] !== e.potential)
                report($sformatf("potential %h, want %h", data[47:0], e.potential));
            if (data[48] !== e.singular_hit)
                report($sformatf("singular_hit %b, want %b", data[48], e.singular_hit));
            if (data[49] !== e.saturated)
                report($sformatf("saturated %b, want %b", data[49], e.saturated));
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [15:0]  i_cfg_data;

    potential_scoreboard sb;

    smoothed_point_charge_potential_grid_unit dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #300_000_000;
        $display("smoothed_point_charge_potential_grid_unit_test NOT OK");
        $finish;
    end

    task automatic send_item(logic cmd, logic [5:0] slot, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [23:0] q, logic [11:0] gi,
                             logic [11:0] gj, logic [11:0] gk);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {6'd0, gk, gj, gi, q, cz, cy, cx, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(cmd, slot, cx, cy, cz, q, gi, gj, gk);
    endtask

    task automatic load_charge(logic [5:0] slot, logic [31:0] cx, logic [31:0] cy,
                               logic [31:0] cz, logic [23:0] q);
        send_item(CMD_LOAD, slot, cx, cy, cz, q, 12'($urandom), 12'($urandom),
                  12'($urandom));
    endtask

    task automatic evaluate(logic [11:0] gi, logic [11:0] gj, logic [11:0] gk);
        send_item(CMD_EVAL, 6'($urandom), $urandom, $urandom, $urandom, 24'($urandom),
                  gi, gj, gk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        sb.write_reg(idx, val);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_potentials.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] sx, logic [15:0] sy, logic [15:0] sz,
                             logic [6:0] cnt);
        drain();
        write_reg(CFG_SPACING_X, sx);
        write_reg(CFG_SPACING_Y, sy);
        write_reg(CFG_SPACING_Z, sz);
        // upper bits of the count write are don't-care
        write_reg(CFG_CHARGE_COUNT, {9'($urandom_range(0, 511)), cnt});
    endtask

    // charge sitting exactly r away along x from the grid point
    task automatic place_singular(logic [5:0] slot, logic [11:0] gi, logic [11:0] gj,
                                  logic [11:0] gk);
        load_charge(slot, gi * sb.spc_x + R_FIX, gj * sb.spc_y, gk * sb.spc_z,
                    24'($urandom_range(1, 24'h7FFFFF)));
    endtask

    function automatic logic [31:0] near(longint unsigned p);
        if ($urandom_range(0, 7) == 0) return $urandom;
        return 32'(p + $signed($urandom_range(0, 1 << 19)) - (1 << 18));
    endfunction

    task automatic random_phase(int items);
        int eff, eval_pct;
        logic [11:0] gi, gj, gk;
        eff = sb.n_charges < TABLE_DEPTH ? sb.n_charges : TABLE_DEPTH;
        eval_pct = eff > 10 ? 15 : 50;
        for (int n = 0; n < items; n++) begin
            gi = 12'($urandom);
            gj = 12'($urandom);
            gk = 12'($urandom);
            if ($urandom_range(0, 99) < eval_pct) begin
                if (eff > 0 && $urandom_range(0, 3) == 0) begin
                    place_singular(6'($urandom_range(0, eff - 1)), gi, gj, gk);
                    n++;
                end else if (eff > 0 && $urandom_range(0, 2) == 0) begin
                    load_charge(6'($urandom_range(0, eff - 1)), near(gi * sb.spc_x),
                                near(gj * sb.spc_y), near(gk * sb.spc_z),
                                24'($urandom));
                    n++;
                end
                evaluate(gi, gj, gk);
            end else begin
                load_charge(6'($urandom), near(gi * sb.spc_x), near(gj * sb.spc_y),
                            near(gk * sb.spc_z), 24'($urandom));
            end
        end
    endtask

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check(m_axis_tdata);
        end
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = CMD_LOAD;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SPACING_X;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset count is zero, so nothing is summed
        evaluate(12'd0, 12'd0, 12'd0);
        evaluate(12'hFFF, 12'hFFF, 12'hFFF);
        // every slot gets a known value before any sum reads it
        for (int s = 0; s < TABLE_DEPTH; s++)
            load_charge(6'(s), $urandom, $urandom, $urandom, 24'($urandom));

        configure(SPACING_RESET, SPACING_RESET, SPACING_RESET, 7'd4);
        place_singular(6'd0, 12'd10, 12'd20, 12'd30);
        load_charge(6'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 24'h800000);
        load_charge(6'd2, 32'd0, 32'd0, 32'd0, 24'd0);
        load_charge(6'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 24'h7FFFFF);
        evaluate(12'd10, 12'd20, 12'd30);
        evaluate(12'd0, 12'd0, 12'd0);
        evaluate(12'hFFF, 12'hFFF, 12'hFFF);
        // charge right on the grid point
        load_charge(6'd2, 32'd0, 32'd0, 32'd0, 24'h7FFFFF);
        load_charge(6'd3, 32'd0, 32'd0, 32'd0, 24'h800000);
        evaluate(12'd0, 12'd0, 12'd0);

        configure(16'd0, 16'd0, 16'd0, 7'd2);
        evaluate(12'hFFF, 12'd1, 12'h800);

        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd3);
        random_phase(70);
        configure(16'd1, 16'd1, 16'd1, 7'd1);
        random_phase(70);
        configure(16'hFFFF, 16'd1, 16'd0, 7'd64);
        random_phase(40);
        configure(16'($urandom), 16'($urandom), 16'($urandom), 7'd0);
        random_phase(60);
        configure(16'($urandom), 16'($urandom), 16'($urandom), 7'd127);
        random_phase(40);
        configure(SPACING_RESET, 16'($urandom), 16'($urandom), 7'd6);
        random_phase(80);
        configure(16'($urandom), 16'($urandom), 16'($urandom), 7'd2);
        random_phase(80);
        configure(16'($urandom), 16'($urandom), 16'($urandom), 7'd10);
        random_phase(70);

        drain();
        $display("covered %0d loads and %0d evaluations, %0d with a charge at distance r",
                 sb.n_loads, sb.n_evals, sb.n_singular);
        $display("spacings from zero to full scale, summed counts 0 to 64 and beyond");
        if (sb.errors == 0) begin
            $display("smoothed_point_charge_potential_grid_unit_test OK");
        end else begin
            $display("smoothed_point_charge_potential_grid_unit_test NOT OK");
        end
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/spcpg_pkg.sv
sv/spcpg_ram.sv
sv/spcpg_isqrt.sv
sv/spcpg_div.sv
sv/smoothed_point_charge_potential_grid_unit.sv
tb/sv/smoothed_point_charge_potential_grid_unit_test.sv
